// File: hw/rtl/rhp_pkg.sv
// RTP header parser package: sizing constants, header masks, result codes
// and the item records shared by the front end, queue and back end.
// No dependencies.
`default_nettype none

package rhp_pkg;

  localparam int unsigned MaxPacketBytes = 2048;
  localparam int unsigned PosW           = $clog2(MaxPacketBytes + 1);
  // 12 + 4*15 + 4 + 4*65535 needs 19 bits
  localparam int unsigned HdrW           = 19;
  localparam int unsigned CalcW          = HdrW + 1;
  localparam int unsigned FixedHdr       = 12;
  localparam int unsigned ExtHdrBytes    = 4;
  localparam int unsigned Sat11          = 2047;

  localparam logic [7:0] VerMask  = 8'b1100_0000;
  localparam logic [7:0] PadMask  = 8'b0010_0000;
  localparam logic [7:0] ExtMask  = 8'b0001_0000;
  localparam logic [7:0] CcMask   = 8'b0000_1111;
  localparam logic [7:0] MarkMask = 8'b1000_0000;
  localparam logic [7:0] PtMask   = 8'b0111_1111;
  localparam logic [1:0] RtpVersion = 2'd2;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_CSRC    = 2'd0,
    KIND_EXT     = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_SHORT        = 4'd1,
    ST_BAD_VERSION  = 4'd2,
    ST_ZERO_PAD     = 4'd3,
    ST_PAD_TOO_BIG  = 4'd4,
    ST_CSRC_OVERRUN = 4'd5,
    ST_EXT_OVERRUN  = 4'd6,
    ST_PAYLOAD_NEG  = 4'd7,
    ST_TOO_LONG     = 4'd8
  } status_e;

  typedef struct packed {
    logic        is_ext;
    logic [31:0] value;
    logic [3:0]  index;
  } word_item_t;

  typedef struct packed {
    status_e     status;
    logic        marker;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [3:0]  cc;
    logic [10:0] offset;
    logic [10:0] size;
    logic [7:0]  pad;
  } summary_t;

  typedef struct packed {
    logic       has_word;
    word_item_t word;
    logic       has_sum;
    summary_t   sum;
  } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/rhp_if.sv
// Valid/ready channel interfaces for the RTP header parser: packet bytes in,
// result items out. No dependencies.
`default_nettype none

interface rhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rhp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  status;
  logic        marker;
  logic [6:0]  pay_type;
  logic [15:0] seq_num;
  logic [31:0] time_stamp;
  logic [31:0] word_value;
  logic [3:0]  item_index;
  logic [10:0] payload_offset;
  logic [10:0] payload_size;
  logic [7:0]  pad_count;
  logic        last_result;

  modport source (
    output valid, output kind, output status, output marker, output pay_type,
    output seq_num, output time_stamp, output word_value, output item_index,
    output payload_offset, output payload_size, output pad_count,
    output last_result, input ready
  );
  modport sink (
    input valid, input kind, input status, input marker, input pay_type,
    input seq_num, input time_stamp, input word_value, input item_index,
    input payload_offset, input payload_size, input pad_count,
    input last_result, output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/rhp_front.sv
// RTP header parser front end: takes one byte per transfer, tracks header fields
// and queues each CSRC word, extension and summary. Depends on rhp_pkg, rhp_if.
`default_nettype none

module rhp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rhp_in_if.sink             in_i,
  input  wire logic          q_ready_i,
  output logic               push_o,
  output rhp_pkg::entry_t    entry_o
);

  logic [rhp_pkg::PosW-1:0]  pos_q, pos_d, upd_pos;
  logic [7:0]                first_q, first_d, upd_first;
  logic [7:0]                second_q, second_d, upd_second;
  logic [15:0]               seq_q, seq_d, upd_seq;
  logic [31:0]               ts_q, ts_d, upd_ts;
  logic [31:0]               ssrc_q, ssrc_d, upd_ssrc;
  logic [31:0]               word_q, word_d, upd_word;
  logic [rhp_pkg::HdrW-1:0]  hdr_q, hdr_d, upd_hdr;
  logic                      over_q, over_d, upd_over;

  logic                      accept;
  logic                      csrc_hit, ext_hit;
  logic [rhp_pkg::CalcW-1:0] word_idx;
  logic [3:0]                cur_cc;
  logic [7:0]                b;

  rhp_pkg::summary_t         sum;

  assign b         = in_i.data_byte;
  assign in_i.ready = q_ready_i;
  assign accept    = in_i.valid && q_ready_i;
  assign cur_cc    = first_q[3:0] & rhp_pkg::CcMask[3:0];
  assign word_idx  = (rhp_pkg::CalcW'(pos_q) >> 2) - rhp_pkg::CalcW'(3);

  always_comb begin
    upd_pos    = pos_q;
    upd_first  = first_q;
    upd_second = second_q;
    upd_seq    = seq_q;
    upd_ts     = ts_q;
    upd_ssrc   = ssrc_q;
    upd_word   = word_q;
    upd_hdr    = hdr_q;
    upd_over   = over_q;
    csrc_hit   = 1'b0;
    ext_hit    = 1'b0;
    if (accept) begin
      if (rhp_pkg::CalcW'(pos_q) >= rhp_pkg::CalcW'(rhp_pkg::MaxPacketBytes)) begin
        upd_over = 1'b1;
      end else begin
        upd_pos = pos_q + 1'b1;
        if (pos_q == '0) begin
          upd_first = b;
          upd_hdr   = rhp_pkg::HdrW'(rhp_pkg::FixedHdr)
                    + rhp_pkg::HdrW'({b[3:0] & rhp_pkg::CcMask[3:0], 2'b00});
        end else if (rhp_pkg::CalcW'(pos_q) == rhp_pkg::CalcW'(1)) begin
          upd_second = b;
        end else if (rhp_pkg::CalcW'(pos_q) < rhp_pkg::CalcW'(4)) begin
          upd_seq = {seq_q[7:0], b};
        end else if (rhp_pkg::CalcW'(pos_q) < rhp_pkg::CalcW'(8)) begin
          upd_ts = {ts_q[23:0], b};
        end else if (rhp_pkg::CalcW'(pos_q) < rhp_pkg::CalcW'(rhp_pkg::FixedHdr)) begin
          upd_ssrc = {ssrc_q[23:0], b};
        end else begin
          upd_word = {word_q[23:0], b};
          if (pos_q[1:0] == 2'b11) begin
            if (word_idx < rhp_pkg::CalcW'(cur_cc)) begin
              csrc_hit = 1'b1;
            end else if (word_idx == rhp_pkg::CalcW'(cur_cc)
                         && (first_q & rhp_pkg::ExtMask) != '0) begin
              ext_hit = 1'b1;
              upd_hdr = rhp_pkg::HdrW'(rhp_pkg::FixedHdr + rhp_pkg::ExtHdrBytes)
                      + rhp_pkg::HdrW'({cur_cc, 2'b00})
                      + rhp_pkg::HdrW'({upd_word[15:0], 2'b00});
            end
          end
        end
      end
    end
  end

  always_comb begin
    logic [rhp_pkg::CalcW-1:0] n, hdr, pad, off, size;
    logic [3:0]                cc;
    logic                      pad_on;
    rhp_pkg::status_e          st;
    cc     = upd_first[3:0] & rhp_pkg::CcMask[3:0];
    n      = rhp_pkg::CalcW'(upd_pos);
    hdr    = rhp_pkg::CalcW'(rhp_pkg::FixedHdr) + rhp_pkg::CalcW'({cc, 2'b00});
    pad_on = (upd_first & rhp_pkg::PadMask) != '0;
    pad    = pad_on ? rhp_pkg::CalcW'(b) : '0;
    off    = hdr;
    st     = rhp_pkg::ST_OK;
    if (upd_over) begin
      st = rhp_pkg::ST_TOO_LONG;
    end else if (n < rhp_pkg::CalcW'(rhp_pkg::FixedHdr)) begin
      st = rhp_pkg::ST_SHORT;
    end else if (((upd_first & rhp_pkg::VerMask) >> 6) != {6'd0, rhp_pkg::RtpVersion}) begin
      st = rhp_pkg::ST_BAD_VERSION;
    end else if (pad_on && b == 8'd0) begin
      st = rhp_pkg::ST_ZERO_PAD;
    end else if (n < pad + rhp_pkg::CalcW'(rhp_pkg::FixedHdr)) begin
      st = rhp_pkg::ST_PAD_TOO_BIG;
    end else if (hdr > n) begin
      st = rhp_pkg::ST_CSRC_OVERRUN;
    end else begin
      if ((upd_first & rhp_pkg::ExtMask) != '0) begin
        if (n < hdr + rhp_pkg::CalcW'(rhp_pkg::ExtHdrBytes)) begin
          st = rhp_pkg::ST_EXT_OVERRUN;
        end else begin
          off = rhp_pkg::CalcW'(upd_hdr);
          if (off > n) begin
            st = rhp_pkg::ST_EXT_OVERRUN;
          end
        end
      end
      if (st == rhp_pkg::ST_OK && off + pad > n) begin
        st = rhp_pkg::ST_PAYLOAD_NEG;
      end
    end
    size = n - off - pad;

    sum.status       = st;
    sum.marker       = (upd_second & rhp_pkg::MarkMask) != '0;
    sum.pt           = upd_second[6:0] & rhp_pkg::PtMask[6:0];
    sum.seq          = upd_seq;
    sum.ts           = upd_ts;
    sum.ssrc         = upd_ssrc;
    sum.cc           = cc;
    if (st != rhp_pkg::ST_OK) begin
      sum.offset = '0;
      sum.size   = '0;
      sum.pad    = '0;
    end else begin
      sum.offset = (off > rhp_pkg::CalcW'(rhp_pkg::Sat11)) ? 11'(rhp_pkg::Sat11) : off[10:0];
      sum.size   = (size > rhp_pkg::CalcW'(rhp_pkg::Sat11)) ? 11'(rhp_pkg::Sat11) : size[10:0];
      sum.pad    = pad[7:0];
    end
  end

  always_comb begin
    entry_o.has_word     = csrc_hit || ext_hit;
    entry_o.word.is_ext  = ext_hit;
    entry_o.word.value   = upd_word;
    entry_o.word.index   = csrc_hit ? word_idx[3:0] : 4'd0;
    entry_o.has_sum      = accept && in_i.last_byte;
    entry_o.sum          = sum;
    push_o               = accept && (csrc_hit || ext_hit || in_i.last_byte);
  end

  always_comb begin
    if (accept && in_i.last_byte) begin
      pos_d    = '0;
      first_d  = '0;
      second_d = '0;
      seq_d    = '0;
      ts_d     = '0;
      ssrc_d   = '0;
      word_d   = '0;
      hdr_d    = rhp_pkg::HdrW'(rhp_pkg::FixedHdr);
      over_d   = 1'b0;
    end else begin
      pos_d    = upd_pos;
      first_d  = upd_first;
      second_d = upd_second;
      seq_d    = upd_seq;
      ts_d     = upd_ts;
      ssrc_d   = upd_ssrc;
      word_d   = upd_word;
      hdr_d    = upd_hdr;
      over_d   = upd_over;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      seq_q    <= '0;
      ts_q     <= '0;
      ssrc_q   <= '0;
      word_q   <= '0;
      hdr_q    <= rhp_pkg::HdrW'(rhp_pkg::FixedHdr);
      over_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
      seq_q    <= seq_d;
      ts_q     <= ts_d;
      ssrc_q   <= ssrc_d;
      word_q   <= word_d;
      hdr_q    <= hdr_d;
      over_q   <= over_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rhp_queue.sv
// RTP header parser record queue between front end and back end.
// Depends on rhp_pkg.
`default_nettype none

module rhp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rhp_pkg::entry_t  entry_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output rhp_pkg::entry_t       entry_o
);

  rhp_pkg::entry_t             mem_q [rhp_pkg::QueueDepth];
  logic [rhp_pkg::QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [rhp_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign ready_o = cnt_q != rhp_pkg::QCntW'(rhp_pkg::QueueDepth);
  assign valid_o = cnt_q != '0;
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == rhp_pkg::QPtrW'(rhp_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == rhp_pkg::QPtrW'(rhp_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rhp_back.sv
// RTP header parser back end: holds one record in the output register and
// sends its word item, if it has one, then its summary, if it has one. Depends on rhp_pkg, rhp_if.
`default_nettype none

module rhp_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire rhp_pkg::entry_t  q_entry_i,
  output logic                  pop_o,
  rhp_out_if.source             out_o
);

  rhp_pkg::entry_t cur_q, cur_d;
  logic            valid_q, valid_d;
  logic            done_q, done_d;
  logic            show_word, xfer, finish, load;

  assign show_word = cur_q.has_word && !done_q;
  assign xfer      = valid_q && out_o.ready;
  assign finish    = xfer && !(show_word && cur_q.has_sum);
  assign load      = !valid_q || finish;
  assign pop_o     = load && q_valid_i;

  always_comb begin
    cur_d   = cur_q;
    valid_d = valid_q;
    done_d  = done_q;
    if (pop_o) begin
      cur_d   = q_entry_i;
      valid_d = 1'b1;
      done_d  = 1'b0;
    end else if (finish) begin
      valid_d = 1'b0;
    end else if (xfer) begin
      done_d = 1'b1;
    end
  end

  always_comb begin
    out_o.valid = valid_q;
    if (show_word) begin
      out_o.kind           = cur_q.word.is_ext ? rhp_pkg::KIND_EXT : rhp_pkg::KIND_CSRC;
      out_o.status         = rhp_pkg::ST_OK;
      out_o.marker         = 1'b0;
      out_o.pay_type       = '0;
      out_o.seq_num        = '0;
      out_o.time_stamp     = '0;
      out_o.word_value     = cur_q.word.value;
      out_o.item_index     = cur_q.word.index;
      out_o.payload_offset = '0;
      out_o.payload_size   = '0;
      out_o.pad_count      = '0;
      out_o.last_result    = 1'b0;
    end else begin
      out_o.kind           = rhp_pkg::KIND_SUMMARY;
      out_o.status         = cur_q.sum.status;
      out_o.marker         = cur_q.sum.marker;
      out_o.pay_type       = cur_q.sum.pt;
      out_o.seq_num        = cur_q.sum.seq;
      out_o.time_stamp     = cur_q.sum.ts;
      out_o.word_value     = cur_q.sum.ssrc;
      out_o.item_index     = cur_q.sum.cc;
      out_o.payload_offset = cur_q.sum.offset;
      out_o.payload_size   = cur_q.sum.size;
      out_o.pad_count      = cur_q.sum.pad;
      out_o.last_result    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rtp_header_parser.sv
// RTP header parser top level: front end, record queue, back end.
// Each result is registered in the record queue, then in the output register.
// Throughput: one byte per cycle while the queue has room; the queue absorbs the
// two items of a final byte that also completes a CSRC or extension header word.
// Reset: decode state, queue and output flags clear at once; no clearing pass.
// Depends on rhp_pkg, rhp_if, rhp_front, rhp_queue, rhp_back.
`default_nettype none

module rtp_header_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rhp_in_if.sink    in_i,
  rhp_out_if.source out_o
);

  logic            push, q_ready, q_valid, pop;
  rhp_pkg::entry_t push_entry, head_entry;

  rhp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  rhp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  rhp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (head_entry),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
